FILE: rtl/core/pstbl_pkg.sv
package pstbl_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int ID_W       = 32;
    localparam int TIME_W     = 32;
    localparam int TOK_W      = 4;
    localparam int PERIOD_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TOK_W-1:0]    BURST_RST  = 4'd6;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BURST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

    // one table slot as stored in the ram
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] base;
        logic [TOK_W-1:0]  tok;
    } entry_t;

    localparam int ENTRY_W = ID_W + TIME_W + TOK_W;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: rtl/core/pstbl_pkt_if.sv
interface pstbl_pkt_if import pstbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   source_node;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output source_node, output time_ms, input ready);
    modport sink (input valid, input source_node, input time_ms, output ready);
endinterface

FILE: rtl/core/pstbl_res_if.sv
interface pstbl_res_if import pstbl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             limited;
    logic [TOK_W-1:0] tokens_left;

    modport source (output valid, output limited, output tokens_left, input ready);
    modport sink (input valid, input limited, input tokens_left, output ready);
endinterface

FILE: rtl/core/pstbl_ram.sv
module pstbl_ram import pstbl_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    localparam int AW   = addr_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/per_source_token_bucket_limiter_unit.sv
// per-source token bucket limiter
//
// pkt channel: one beat per received packet (source_node, time_ms in ms).
// res channel: one beat per packet, limited = drop it, tokens_left = tokens
// the source holds afterwards.
// cfg port: cfg_wr_en/cfg_idx/cfg_data, index 0 = burst_tokens,
// index 1 = refill_period_ms; write only while the block is idle.
//
// one packet at a time: pkt.ready is high only in idle. a packet walks the
// slot table one ram read per cycle, then a last compare step and a decide
// step; a miss goes straight to write-back, while a hit runs a restoring divider
// that makes one quotient bit per cycle to get the whole refill periods
// elapsed, then an apply step for the refill, then the write-back. the result
// beat is registered with the write-back, which waits until the output
// register is free; the next packet is taken once the block is back in idle.
//
// reset clears the per-slot valid flags, so every slot reads as empty
// (id 0, base 0, no tokens) with no clearing pass; config goes to defaults.
// res has an output register: a new packet is accepted while a result beat
// waits, and the block holds its write-back until the receiver takes it.
module per_source_token_bucket_limiter_unit import pstbl_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pstbl_pkt_if.sink             pkt,
    pstbl_res_if.source           res,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = addr_w(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TIME_W);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_LAST   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_APPLY  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [TOK_W-1:0]    burst_reg;
    logic [PERIOD_W-1:0] period_reg;

    // packet under work
    logic [ID_W-1:0]   src_reg;
    logic [TIME_W-1:0] now_reg;

    // table walk
    logic [AW-1:0]            scan_reg;
    logic                     cmp_vld_reg;
    logic [AW-1:0]            cmp_idx_reg;
    logic                     cmp_ent_vld_reg;
    logic [TABLE_ENTRIES-1:0] valid_bits_reg;

    logic              hit_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [TIME_W-1:0] hit_base_reg;
    logic [TOK_W-1:0]  hit_tok_reg;
    logic              empty_reg;
    logic [AW-1:0]     empty_idx_reg;
    logic [TIME_W-1:0] min_base_reg;
    logic [AW-1:0]     min_idx_reg;

    // divider
    logic [TIME_W-1:0]   quot_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [CNT_W-1:0]    div_cnt_reg;

    // write-back and result
    logic [AW-1:0]     slot_reg;
    logic [TIME_W-1:0] new_base_reg;
    logic [TOK_W-1:0]  new_tok_reg;
    logic              new_lim_reg;
    logic              res_valid_reg;
    logic              res_limited_reg;
    logic [TOK_W-1:0]  res_tok_reg;

    // ram
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             wr_entry;

    logic pkt_fire;
    logic out_free;

    logic id_match;
    logic id_empty;
    logic base_older;

    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   div_trial;
    logic                div_ge;
    logic [PERIOD_W:0]   div_diff;

    logic             gain_big;
    logic [TOK_W:0]   tok_sum;
    logic [TOK_W-1:0] tok_refill;
    logic [TOK_W-1:0] tok_after;
    logic [TIME_W-1:0] base_after;

    assign pkt_fire  = pkt.valid && pkt.ready;
    assign out_free  = !res_valid_reg || res.ready;
    assign pkt.ready = (state_reg == S_IDLE);

    assign res.valid       = res_valid_reg;
    assign res.limited     = res_limited_reg;
    assign res.tokens_left = res_tok_reg;

    // a slot never written reads as empty
    assign rd_entry   = cmp_ent_vld_reg ? entry_t'(ram_rdata) : '0;
    assign id_match   = (rd_entry.id == src_reg);
    assign id_empty   = (rd_entry.id == '0);
    assign base_older = (rd_entry.base < min_base_reg);

    // a zero period counts as one ms
    assign period_eff = (period_reg == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : period_reg;
    assign div_trial  = {rem_reg, quot_reg[TIME_W-1]};
    assign div_ge     = (div_trial >= {1'b0, period_eff});
    assign div_diff   = div_trial - {1'b0, period_eff};

    // refill: gained = quot, remainder says how far now is past the new base
    assign gain_big   = |quot_reg[TIME_W-1:TOK_W];
    assign tok_sum    = {1'b0, hit_tok_reg} + {1'b0, quot_reg[TOK_W-1:0]};
    assign tok_refill = (gain_big || (tok_sum > {1'b0, burst_reg})) ?
                        burst_reg : tok_sum[TOK_W-1:0];
    assign tok_after  = (quot_reg != '0) ? tok_refill : hit_tok_reg;
    assign base_after = (quot_reg != '0) ?
                        (now_reg - {{(TIME_W-PERIOD_W){1'b0}}, rem_reg}) : hit_base_reg;

    assign ram_re = (state_reg == S_SCAN);
    assign ram_we = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        wr_entry.id   = src_reg;
        wr_entry.base = new_base_reg;
        wr_entry.tok  = new_tok_reg;
    end
    assign ram_wdata = wr_entry;

    pstbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pkt_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = hit_reg ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_cnt_reg == CNT_W'(TIME_W - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            burst_reg      <= BURST_RST;
            period_reg     <= PERIOD_RST;
            valid_bits_reg <= '0;
            res_valid_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            empty_reg      <= 1'b0;
            scan_reg       <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_idx)
                    REG_BURST:  burst_reg  <= cfg_data[TOK_W-1:0];
                    REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    default:    ;
                endcase
            end

            if (pkt_fire)
            begin
                scan_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                empty_reg   <= 1'b0;
            end

            if (state_reg == S_SCAN)
            begin
                cmp_vld_reg <= 1'b1;
                if (scan_reg != AW'(TABLE_ENTRIES - 1))
                begin
                    scan_reg <= scan_reg + AW'(1);
                end
            end

            if (state_reg == S_LAST)
            begin
                cmp_vld_reg <= 1'b0;
            end

            // first match is the hit, first empty slot is the claim target
            if (cmp_vld_reg)
            begin
                if (id_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (id_empty && !empty_reg)
                begin
                    empty_reg <= 1'b1;
                end
            end

            if (state_reg == S_DECIDE)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end

            if (ram_we)
            begin
                valid_bits_reg[slot_reg] <= 1'b1;
                res_valid_reg            <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pkt_fire)
        begin
            src_reg      <= pkt.source_node;
            now_reg      <= pkt.time_ms;
            min_base_reg <= '1;
            min_idx_reg  <= '0;
        end

        if (state_reg == S_SCAN)
        begin
            cmp_idx_reg     <= scan_reg;
            cmp_ent_vld_reg <= valid_bits_reg[scan_reg];
        end

        if (cmp_vld_reg)
        begin
            if (id_match && !hit_reg)
            begin
                hit_idx_reg  <= cmp_idx_reg;
                hit_base_reg <= rd_entry.base;
                hit_tok_reg  <= rd_entry.tok;
            end
            if (id_empty && !empty_reg)
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
            if (base_older)
            begin
                min_base_reg <= rd_entry.base;
                min_idx_reg  <= cmp_idx_reg;
            end
        end

        case (state_reg)
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    slot_reg <= hit_idx_reg;
                    quot_reg <= now_reg - hit_base_reg;
                    rem_reg  <= '0;
                end
                else
                begin
                    slot_reg     <= empty_reg ? empty_idx_reg : min_idx_reg;
                    new_base_reg <= now_reg;
                    new_tok_reg  <= (burst_reg == '0) ? '0 : (burst_reg - TOK_W'(1));
                    new_lim_reg  <= 1'b0;
                end
            end
            S_DIV:
            begin
                quot_reg <= {quot_reg[TIME_W-2:0], div_ge};
                rem_reg  <= div_ge ? div_diff[PERIOD_W-1:0] : div_trial[PERIOD_W-1:0];
            end
            S_APPLY:
            begin
                new_base_reg <= base_after;
                new_lim_reg  <= (tok_after == '0);
                new_tok_reg  <= (tok_after == '0) ? '0 : (tok_after - TOK_W'(1));
            end
            default:
            begin
            end
        endcase

        if (ram_we)
        begin
            res_limited_reg <= new_lim_reg;
            res_tok_reg     <= new_tok_reg;
        end
    end

`ifndef SYNTH
    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_fire |=> (state_reg == S_SCAN))
        else $error("accepted packet did not start the table walk");

    a_limited_has_no_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.limited) |-> (res.tokens_left == '0))
        else $error("limited packet reports tokens left");

    a_writeback_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> res.valid)
        else $error("table write-back without a result beat");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !pkt.ready)
        else $error("packet taken while divider is running");
`endif

endmodule
